// ===== rtl/lsra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Linear scan register allocator package
// Field widths, request and result types, event and queue operation codes.
// ----------------------------------------------------------------------------
package lsra_pkg;

    localparam int NUM_PHYS_REGS = 8;
    localparam int ID_W   = 8;
    localparam int POS_W  = 16;
    localparam int PHYS_W = 3;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] EV_FREE  = 2'd0;
    localparam logic [KIND_W-1:0] EV_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] EV_XFER  = 2'd2;
    localparam logic [KIND_W-1:0] EV_ORDER = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  interval_id;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
    } t_lsra_req;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [ID_W-1:0]   subject_id;
        logic [ID_W-1:0]   spilled_id;
        logic [PHYS_W-1:0] phys_reg;
        logic              last;
    } t_lsra_res;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  end_pos;
        logic [PHYS_W-1:0] phys;
    } t_lsra_slot;

    typedef struct packed {
        logic       valid;
        t_lsra_slot slot;
    } t_lsra_entry;

    typedef struct packed {
        logic [1:0] op;
        t_lsra_slot slot;
    } t_lsra_ctl;

endpackage
`default_nettype wire

// ===== rtl/lsra_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted queue cell
// Holds one active interval. The row keeps intervals ordered by end, then by
// physical register; a pop shifts every cell toward the head, an insert
// shifts the cells behind the insertion point away from it.
// ----------------------------------------------------------------------------
module lsra_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lsra_pkg::t_lsra_ctl    i_ctl,
    input  lsra_pkg::t_lsra_entry  i_left,
    input  wire                    i_left_lt,
    input  lsra_pkg::t_lsra_entry  i_right,
    output lsra_pkg::t_lsra_entry  o_entry,
    output logic                   o_lt
);

    logic                 r_valid;
    logic                 n_valid;
    lsra_pkg::t_lsra_slot r_slot;
    lsra_pkg::t_lsra_slot n_slot;
    logic                 w_key_less;

    // The new interval belongs ahead of this cell's entry.
    assign w_key_less = (i_ctl.slot.end_pos < r_slot.end_pos) ||
                        ((i_ctl.slot.end_pos == r_slot.end_pos) &&
                         (i_ctl.slot.phys < r_slot.phys));
    assign o_lt = !r_valid || w_key_less;

    assign o_entry.valid = r_valid;
    assign o_entry.slot  = r_slot;

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        case (i_ctl.op)
            lsra_pkg::OP_POP: begin
                n_valid = i_right.valid;
                n_slot  = i_right.slot;
            end
            lsra_pkg::OP_INSERT: begin
                if (o_lt) begin
                    if (i_left_lt) begin
                        n_valid = i_left.valid;
                        n_slot  = i_left.slot;
                    end else begin
                        n_valid = 1'b1;
                        n_slot  = i_ctl.slot;
                    end
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule
`default_nettype wire

// ===== rtl/linear_scan_register_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Linear scan register allocator
// Expires, spills and grants physical registers for live intervals that
// arrive in start order, using a sorted row of interval cells.
// ----------------------------------------------------------------------------
// An interval request is served from the head cell of the sorted row: one
// result leaves per cycle when the results are taken as they appear, and
// the final insertion into the row overlaps the acceptance of the next
// request. A request that arrives out of start order leaves the state
// untouched. A waiting result in the output register does not block
// acceptance of the next request.
module linear_scan_register_allocator (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  lsra_pkg::t_lsra_req   i_in_req,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output lsra_pkg::t_lsra_res   o_out_res
);

    localparam int NUM_PHYS_REGS = lsra_pkg::NUM_PHYS_REGS;
    localparam int PW = lsra_pkg::PHYS_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPIRE = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    lsra_pkg::t_lsra_req         r_req;
    logic [NUM_PHYS_REGS-1:0]    r_free;
    logic [NUM_PHYS_REGS-1:0]    n_free;
    logic [lsra_pkg::POS_W-1:0]  r_last_start;
    logic [lsra_pkg::POS_W-1:0]  n_last_start;
    logic [PW-1:0]               r_ins_phys;
    logic [PW-1:0]               n_ins_phys;
    logic                        r_out_valid;
    lsra_pkg::t_lsra_res         r_out_res;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_emit;
    lsra_pkg::t_lsra_res         w_res;
    lsra_pkg::t_lsra_ctl         w_ctl;
    lsra_pkg::t_lsra_entry       w_ent [NUM_PHYS_REGS];
    logic [NUM_PHYS_REGS-1:0]    w_lt;
    logic [NUM_PHYS_REGS-1:0]    w_valid_vec;
    lsra_pkg::t_lsra_entry       w_head;
    logic                        w_order_err;
    logic                        w_expire;
    logic                        w_full;
    logic [PW-1:0]               w_low_free;

    // Sorted row of active intervals; cell 0 holds the earliest end.
    for (genvar g = 0; g < NUM_PHYS_REGS; g++) begin : g_cell
        lsra_pkg::t_lsra_entry w_left;
        lsra_pkg::t_lsra_entry w_right;
        logic                  w_left_lt;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_lt = 1'b0;
        end else begin : g_inner
            assign w_left    = w_ent[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == NUM_PHYS_REGS - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_ent[g+1];
        end

        lsra_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_entry   (w_ent[g]),
            .o_lt      (w_lt[g])
        );

        assign w_valid_vec[g] = w_ent[g].valid;
    end

    assign w_head      = w_ent[0];
    assign o_in_stall  = (r_state == ST_EXPIRE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_order_err = (r_req.start_pos < r_last_start);
    assign w_expire    = w_head.valid && (w_head.slot.end_pos < r_req.start_pos);
    assign w_full      = (r_free == '0);

    always_comb begin
        w_low_free = '0;
        for (int i = NUM_PHYS_REGS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_low_free = PW'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free       = r_free;
        n_last_start = r_last_start;
        n_ins_phys   = r_ins_phys;
        w_emit       = 1'b0;
        w_res        = '0;
        w_ctl.op     = lsra_pkg::OP_HOLD;
        w_ctl.slot.id      = r_req.interval_id;
        w_ctl.slot.end_pos = r_req.end_pos;
        w_ctl.slot.phys    = r_ins_phys;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXPIRE;
                end
            end
            ST_EXPIRE: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (w_order_err) begin
                        w_res.event_kind = lsra_pkg::EV_ORDER;
                        w_res.subject_id = r_req.interval_id;
                        w_res.last       = 1'b1;
                        n_state          = ST_IDLE;
                    end else if (w_expire) begin
                        w_res.event_kind = lsra_pkg::EV_FREE;
                        w_res.subject_id = w_head.slot.id;
                        w_res.phys_reg   = w_head.slot.phys;
                        w_ctl.op         = lsra_pkg::OP_POP;
                        n_free = r_free | (NUM_PHYS_REGS'(1) << w_head.slot.phys);
                    end else if (w_full) begin
                        // Every register is held: the earliest end gives its
                        // register to the new interval and goes to the stack.
                        w_res.event_kind = lsra_pkg::EV_XFER;
                        w_res.subject_id = r_req.interval_id;
                        w_res.spilled_id = w_head.slot.id;
                        w_res.phys_reg   = w_head.slot.phys;
                        w_res.last       = 1'b1;
                        w_ctl.op         = lsra_pkg::OP_POP;
                        n_ins_phys       = w_head.slot.phys;
                        n_last_start     = r_req.start_pos;
                        n_state          = ST_INSERT;
                    end else begin
                        w_res.event_kind = lsra_pkg::EV_ALLOC;
                        w_res.subject_id = r_req.interval_id;
                        w_res.phys_reg   = w_low_free;
                        w_res.last       = 1'b1;
                        n_free = r_free & ~(NUM_PHYS_REGS'(1) << w_low_free);
                        n_ins_phys       = w_low_free;
                        n_last_start     = r_req.start_pos;
                        n_state          = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                w_ctl.op = lsra_pkg::OP_INSERT;
                n_state  = w_accept ? ST_EXPIRE : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free       <= '1;
            r_last_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free       <= n_free;
            r_last_start <= n_last_start;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins_phys <= n_ins_phys;
        if (w_accept) begin
            r_req <= i_in_req;
        end
        if (w_out_free) begin
            r_out_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // Every register is either free or held by exactly one cell, except the
    // one whose new interval is still waiting to be written into the row.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_valid_vec) + $countones(r_free) +
         ((r_state == ST_INSERT) ? 1 : 0)) == NUM_PHYS_REGS)
        else $error("free map and interval row disagree on occupancy");

    // The head interval's register is never marked free.
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_head.valid |-> ((r_free & (NUM_PHYS_REGS'(1) << w_head.slot.phys)) == '0))
        else $error("head interval holds a register marked free");

    // With no free register the row has an interval to spill.
    a_spill_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> w_head.valid)
        else $error("all registers held but interval row is empty");

    // Only free events can be followed by more results of the same request.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.last) |-> (o_out_res.event_kind == lsra_pkg::EV_FREE))
        else $error("non-final result is not a free event");

    // A request rejected for start order leaves the last start unchanged.
    a_order_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPIRE && w_out_free && w_order_err) |=> $stable(r_last_start))
        else $error("out-of-order request changed the last start");

endmodule
`default_nettype wire

// ===== tb/lsra_allocation_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Linear scan allocator checker
// Watches the request and result channels. For every accepted request it
// works out the free, allocate, transfer and order error events, then
// compares each accepted result with the oldest event still awaited.
// ----------------------------------------------------------------------------
module lsra_allocation_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  lsra_pkg::t_lsra_req i_in_req,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  lsra_pkg::t_lsra_res i_out_res,
    output int                  o_pending,
    output int                  o_fail_count
);

    localparam int NUM_REGS = lsra_pkg::NUM_PHYS_REGS;

    logic [NUM_REGS-1:0]        held;
    logic [lsra_pkg::ID_W-1:0]  owner_id  [NUM_REGS];
    logic [lsra_pkg::POS_W-1:0] owner_end [NUM_REGS];
    logic [NUM_REGS-1:0]        free_regs;
    logic [lsra_pkg::POS_W-1:0] prev_start;
    lsra_pkg::t_lsra_res        awaited_events [$];
    int                         mismatches = 0;

    assign o_fail_count = mismatches;

    // Held register with the smallest end; the lowest index wins a tie.
    function automatic int earliest_holder();
        int best;
        best = -1;
        for (int p = 0; p < NUM_REGS; p++) begin
            if (held[p] && (best < 0 || owner_end[p] < owner_end[best])) begin
                best = p;
            end
        end
        return best;
    endfunction

    task automatic push_event(input logic [lsra_pkg::KIND_W-1:0] kind,
                              input logic [lsra_pkg::ID_W-1:0] subj,
                              input logic [lsra_pkg::ID_W-1:0] spilled,
                              input int reg_idx, input logic last_flag);
        lsra_pkg::t_lsra_res ev;
        ev.event_kind = kind;
        ev.subject_id = subj;
        ev.spilled_id = spilled;
        ev.phys_reg   = lsra_pkg::PHYS_W'(reg_idx);
        ev.last       = last_flag;
        awaited_events.push_back(ev);
    endtask

    task automatic predict_allocation(input lsra_pkg::t_lsra_req req);
        int s;
        int p;
        if (req.start_pos < prev_start) begin
            push_event(lsra_pkg::EV_ORDER, req.interval_id, '0, 0, 1'b1);
            return;
        end
        prev_start = req.start_pos;

        s = earliest_holder();
        while (s >= 0 && owner_end[s] < req.start_pos) begin
            held[s]      = 1'b0;
            free_regs[s] = 1'b1;
            push_event(lsra_pkg::EV_FREE, owner_id[s], '0, s, 1'b0);
            s = earliest_holder();
        end

        if (free_regs == '0) begin
            // Every register is held: the earliest end gives up its register.
            push_event(lsra_pkg::EV_XFER, req.interval_id, owner_id[s], s, 1'b1);
            owner_id[s]  = req.interval_id;
            owner_end[s] = req.end_pos;
            return;
        end

        p = 0;
        while (!free_regs[p]) p++;
        free_regs[p] = 1'b0;
        held[p]      = 1'b1;
        owner_id[p]  = req.interval_id;
        owner_end[p] = req.end_pos;
        push_event(lsra_pkg::EV_ALLOC, req.interval_id, '0, p, 1'b1);
    endtask

    task automatic check_event(input lsra_pkg::t_lsra_res got);
        lsra_pkg::t_lsra_res want;
        if (awaited_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result: kind %0d subject %0d spilled %0d reg %0d last %0b",
                         got.event_kind, got.subject_id, got.spilled_id, got.phys_reg,
                         got.last);
            end
            return;
        end
        want = awaited_events.pop_front();
        if (got.event_kind !== want.event_kind || got.subject_id !== want.subject_id ||
            got.spilled_id !== want.spilled_id || got.phys_reg !== want.phys_reg ||
            got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result mismatch at %0t:", $realtime);
                $display("  expected kind %0d subject %0d spilled %0d reg %0d last %0b",
                         want.event_kind, want.subject_id, want.spilled_id,
                         want.phys_reg, want.last);
                $display("  got      kind %0d subject %0d spilled %0d reg %0d last %0b",
                         got.event_kind, got.subject_id, got.spilled_id, got.phys_reg,
                         got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held       = '0;
            free_regs  = '1;
            prev_start = '0;
            awaited_events.delete();
        end else begin
            // A result never comes from the request taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                check_event(i_out_res);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_allocation(i_in_req);
            end
        end
        o_pending <= awaited_events.size();
    end

endmodule
`default_nettype wire

// ===== tb/linear_scan_register_allocator_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Linear scan register allocator test
// Sends directed and random live intervals with random gaps and result
// stalls, including a long result hold-off and a full drain, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_test;

    localparam int RANDOM_ITEMS = 80;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    lsra_pkg::t_lsra_req in_req    = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    lsra_pkg::t_lsra_res out_res;
    int                  pending;
    int                  fail_count;
    bit                  calm      = 1'b0;
    int                  hold_len  = 0;

    linear_scan_register_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res)
    );

    lsra_allocation_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_res    (out_res),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Valid stays high when the next request follows with no gap.
    task automatic send_interval(input logic [lsra_pkg::ID_W-1:0] id,
                                 input logic [lsra_pkg::POS_W-1:0] s,
                                 input logic [lsra_pkg::POS_W-1:0] e);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{interval_id: id, start_pos: s, end_pos: e};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial begin : result_sink
        int n;
        wait (rst_n);
        forever begin
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            n = draw_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial begin : stimulus
        int                         cursor;
        int                         cand;
        int                         n_sent;
        int                         burst;
        int                         pick;
        bit                         held_off;
        bit                         paused;
        logic [lsra_pkg::ID_W-1:0]  id;
        logic [lsra_pkg::POS_W-1:0] e;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill all eight registers, spill on tied ends, accept an end below
        // its start, then expire six intervals with one request.
        send_interval(8'h00, 16'd0, 16'd0);
        send_interval(8'hFF, 16'd0, 16'hFFFF);
        send_interval(8'h01, 16'd1, 16'd10);
        send_interval(8'h02, 16'd1, 16'd10);
        send_interval(8'h03, 16'd1, 16'd10);
        send_interval(8'h04, 16'd2, 16'd10);
        send_interval(8'h05, 16'd2, 16'd10);
        send_interval(8'h06, 16'd2, 16'd10);
        send_interval(8'h07, 16'd3, 16'd10);
        send_interval(8'h08, 16'd3, 16'd12);
        send_interval(8'h09, 16'd4, 16'd5);
        send_interval(8'h0A, 16'd4, 16'd3);
        send_interval(8'h0B, 16'd2, 16'd50);
        send_interval(8'h55, 16'd11, 16'd20);
        send_interval(8'hAA, 16'd11, 16'd20);
        send_interval(8'h0C, 16'd10, 16'd0);

        // Bursts of overlapping intervals; the start position climbs over
        // the whole range so that every start bit toggles.
        cursor   = 11;
        n_sent   = 0;
        held_off = 1'b0;
        paused   = 1'b0;
        while (n_sent < RANDOM_ITEMS) begin
            if (!held_off && n_sent >= 10) begin
                held_off = 1'b1;
                hold_len = 300;
            end
            if (!paused && n_sent >= 60) begin
                paused = 1'b1;
                drain_results();
            end
            calm = (n_sent % 40) >= 25;
            cand = n_sent * 65000 / RANDOM_ITEMS - int'($urandom_range(0, 150));
            if (cand > cursor) cursor = cand;
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                id = lsra_pkg::ID_W'($urandom_range(0, 255));
                if ($urandom_range(0, 15) == 0 && cursor > 0) begin
                    send_interval(id, lsra_pkg::POS_W'($urandom_range(0, cursor - 1)),
                                  lsra_pkg::POS_W'($urandom));
                end else begin
                    cursor = cursor + int'($urandom_range(0, 3));
                    if (cursor > 65535) cursor = 65535;
                    pick = $urandom_range(0, 9);
                    if (pick == 0) begin
                        e = '1;
                    end else if (pick == 1) begin
                        e = lsra_pkg::POS_W'($urandom_range(0, cursor));
                    end else begin
                        e = lsra_pkg::POS_W'(cursor + int'($urandom_range(0, 60)));
                    end
                    send_interval(id, lsra_pkg::POS_W'(cursor), e);
                    n_sent++;
                end
            end
        end

        calm = 1'b0;
        send_interval(8'hFF, 16'hFFFF, 16'hFFFF);
        send_interval(8'h80, 16'hFFFF, 16'hFFFF);
        send_interval(8'h00, 16'hFFFF, 16'h0000);
        send_interval(8'h7F, 16'h0000, 16'hFFFF);

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/lsra_pkg.sv
rtl/lsra_cell.sv
rtl/linear_scan_register_allocator.sv
tb/lsra_allocation_checker.sv
tb/linear_scan_register_allocator_test.sv
